@@ hw/rtl/swcm_pkg.sv @@
// ----------------------------------------------------------------------------
// swcm_pkg
// Types, formats and constants shared by the spherical warp coordinate map.
// ----------------------------------------------------------------------------
package swcm_pkg;

  localparam int COORD_BITS   = 13;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 16;

  localparam int REG_W     = 24;
  localparam int OUT_W     = 24;
  localparam int ANG_FRAC  = 30;
  localparam int CFG_IDX_W = 8;

  // angle divider
  localparam int CQ_W  = COORD_BITS + FRAC_BITS;
  localparam int MAG_W = (CQ_W > REG_W) ? CQ_W : REG_W;
  localparam int AD_W  = MAG_W + ANG_FRAC;
  localparam int AR_W  = REG_W + 1;
  localparam int MOD_W = 34;
  localparam int ANG_W = 34;

  // cordic and projection
  localparam int CS_W  = 33;
  localparam int PN_W  = REG_W + CS_W;
  localparam int PD_W  = CS_W - 1;
  localparam int PR_W  = PD_W + 1;
  localparam int SUM_W = PN_W + 2;

  localparam logic [MOD_W-1:0]        TWO_PI_Q  = 34'd6746518852;
  localparam logic signed [ANG_W-1:0] PI_Q      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q = 34'sd1686629713;
  localparam logic signed [CS_W-1:0]  GAIN_Q    = 33'sd652032874;

  localparam logic signed [SUM_W-1:0] SUM_HI = (1 <<< (OUT_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0] SUM_LO = -(1 <<< (OUT_W - 1));
  localparam logic signed [OUT_W-1:0] OUT_HI = SUM_HI[OUT_W-1:0];
  localparam logic signed [OUT_W-1:0] OUT_LO = SUM_LO[OUT_W-1:0];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] source_x;
    logic signed [OUT_W-1:0] source_y;
    logic                    out_of_range;
  } out_beat_t;

  // sideband through the projection divider
  typedef struct packed {
    logic neg;
    logic zbad;
  } pdiv_side_t;

  function automatic logic signed [ANG_W-1:0] atan_q(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/swcm_angle_div.sv @@
// ----------------------------------------------------------------------------
// swcm_angle_div
// Pipelined angle divider: |coord - center| / focal in Q.30, one quotient bit
// per stage, with the quotient reduced modulo 2*pi as its bits arrive.
// ----------------------------------------------------------------------------
module swcm_angle_div
  import swcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [COORD_BITS-1:0]   coord,
  input  logic [REG_W-1:0]        center,
  input  logic [REG_W-1:0]        focal,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] angle
);

  logic [REG_W-1:0] div_e;
  logic [MAG_W-1:0] cq, ce, mag;
  logic             neg;

  assign div_e = (focal == '0) ? REG_W'(1) : focal;
  assign cq    = MAG_W'(coord) << FRAC_BITS;
  assign ce    = MAG_W'(center);
  assign neg   = cq < ce;
  assign mag   = neg ? (ce - cq) : (cq - ce);

  logic             v_r   [0:AD_W];
  logic [AD_W-1:0]  dvd_r [0:AD_W];
  logic [AR_W-1:0]  rem_r [0:AD_W];
  logic [MOD_W-1:0] acc_r [0:AD_W];
  logic             neg_r [0:AD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd_r[0] <= {mag, {ANG_FRAC{1'b0}}};
      rem_r[0] <= '0;
      acc_r[0] <= '0;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 0; k < AD_W; k++) begin : g_bit
    logic [AR_W-1:0]  rem_sh, rem_nxt;
    logic [MOD_W-1:0] acc_sh, acc_nxt;
    logic             ge;

    always_comb begin
      rem_sh  = {rem_r[k][AR_W-2:0], dvd_r[k][AD_W-1]};
      ge      = rem_sh >= {1'b0, div_e};
      rem_nxt = ge ? (rem_sh - {1'b0, div_e}) : rem_sh;
      acc_sh  = {acc_r[k][MOD_W-2:0], ge};
      acc_nxt = (acc_sh >= TWO_PI_Q) ? (acc_sh - TWO_PI_Q) : acc_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvd_r[k+1] <= dvd_r[k] << 1;
        rem_r[k+1] <= rem_nxt;
        acc_r[k+1] <= acc_nxt;
        neg_r[k+1] <= neg_r[k];
      end
    end
  end

  // fold into (-pi, pi], then apply the sign
  logic signed [ANG_W-1:0] a_red, a_nxt;
  logic                    out_valid_r;
  logic signed [ANG_W-1:0] angle_r;

  always_comb begin
    a_red = $signed(acc_r[AD_W]);
    if (a_red > PI_Q) begin
      a_red = a_red - $signed(TWO_PI_Q);
    end
    a_nxt = neg_r[AD_W] ? -a_red : a_red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[AD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r <= a_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign angle     = angle_r;

endmodule

@@ hw/rtl/swcm_cordic.sv @@
// ----------------------------------------------------------------------------
// swcm_cordic
// Pipelined rotation-mode cordic, one micro-rotation per stage, Q.30 sin/cos.
// ----------------------------------------------------------------------------
module swcm_cordic
  import swcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] angle,
  output logic                    out_valid,
  output logic signed [CS_W-1:0]  cos_q,
  output logic signed [CS_W-1:0]  sin_q
);

  logic                    v_r    [0:CORDIC_STEPS];
  logic signed [CS_W-1:0]  x_r    [0:CORDIC_STEPS];
  logic signed [CS_W-1:0]  y_r    [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] z_r    [0:CORDIC_STEPS];
  logic                    flip_r [0:CORDIC_STEPS];

  logic signed [ANG_W-1:0] z0;
  logic                    flip0;

  // fold into [-pi/2, pi/2]
  always_comb begin
    z0    = angle;
    flip0 = 1'b0;
    if (angle > HALF_PI_Q) begin
      z0    = angle - PI_Q;
      flip0 = 1'b1;
    end else if (angle < -HALF_PI_Q) begin
      z0    = angle + PI_Q;
      flip0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= GAIN_Q;
      y_r[0]    <= '0;
      z_r[0]    <= z0;
      flip_r[0] <= flip0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CS_W-1:0]  x_nxt, y_nxt;
    logic signed [ANG_W-1:0] z_nxt;

    always_comb begin
      if (z_r[i] >= 0) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - atan_q(i);
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + atan_q(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  logic                   out_valid_r;
  logic signed [CS_W-1:0] cos_r, sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r <= flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      sin_r <= flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

  assign out_valid = out_valid_r;
  assign cos_q     = cos_r;
  assign sin_q     = sin_r;

endmodule

@@ hw/rtl/swcm_proj_div.sv @@
// ----------------------------------------------------------------------------
// swcm_proj_div
// Pipelined signed divider for the projection, truncating toward zero,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module swcm_proj_div
  import swcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [PN_W:0] num,
  input  logic [PD_W-1:0]      den,
  input  logic                 zbad,
  output logic                 out_valid,
  output logic signed [PN_W:0] quot,
  output logic                 out_zbad
);

  logic            v_r    [0:PN_W];
  logic [PN_W-1:0] dvd_r  [0:PN_W];
  logic [PR_W-1:0] rem_r  [0:PN_W];
  logic [PN_W-1:0] q_r    [0:PN_W];
  logic [PD_W-1:0] den_r  [0:PN_W];
  pdiv_side_t      side_r [0:PN_W];

  logic [PN_W:0] mag;
  assign mag = num[PN_W] ? -num : num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvd_r[0]       <= mag[PN_W-1:0];
      rem_r[0]       <= '0;
      q_r[0]         <= '0;
      den_r[0]       <= den;
      side_r[0].neg  <= num[PN_W];
      side_r[0].zbad <= zbad;
    end
  end

  for (genvar k = 0; k < PN_W; k++) begin : g_bit
    logic [PR_W-1:0] rem_sh, rem_nxt;
    logic            ge;

    always_comb begin
      rem_sh  = {rem_r[k][PR_W-2:0], dvd_r[k][PN_W-1]};
      ge      = rem_sh >= {1'b0, den_r[k]};
      rem_nxt = ge ? (rem_sh - {1'b0, den_r[k]}) : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dvd_r[k+1]  <= dvd_r[k] << 1;
        rem_r[k+1]  <= rem_nxt;
        q_r[k+1]    <= {q_r[k][PN_W-2:0], ge};
        den_r[k+1]  <= den_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  logic                 out_valid_r, zbad_r;
  logic signed [PN_W:0] quot_r;
  logic signed [PN_W:0] q_pos;

  assign q_pos = $signed({1'b0, q_r[PN_W]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[PN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot_r <= side_r[PN_W].neg ? -q_pos : q_pos;
      zbad_r <= side_r[PN_W].zbad;
    end
  end

  assign out_valid = out_valid_r;
  assign quot      = quot_r;
  assign out_zbad  = zbad_r;

endmodule

@@ hw/rtl/spherical_warp_coordinate_map.sv @@
// ----------------------------------------------------------------------------
// spherical_warp_coordinate_map
// Maps a destination pixel to its source coordinate under a spherical warp.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock unless stalled and returns one
// coordinate beat per pixel, in order. Most of the pipeline lies in the two
// bit-per-stage dividers (angle and projection) and the cordic rotation
// stages. The whole pipeline moves on one advance signal: it holds when the
// output register is full and the sink is not ready, so in_ready is low
// exactly when a result beat is stuck. Results are signed Q16.8, clamped to
// the 24-bit range; out_of_range flags a depth term at or below zero (both
// coordinates then read the positive limit) or a clamped coordinate.
// Registers are written through the cfg port, always ready, and must only
// change while no pixel is in flight; writes to an unknown index are dropped,
// and a focal length of zero acts as one in the angle dividers.
module spherical_warp_coordinate_map
  import swcm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_beat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  // configuration registers
  logic [REG_W-1:0] focal_x_r, focal_y_r, center_x_r, center_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= REG_W'(131428);
      focal_y_r  <= REG_W'(131549);
      center_x_r <= REG_W'(91567);
      center_y_r <= REG_W'(141089);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FOCAL_X:  focal_x_r  <= cfg_data;
        REG_FOCAL_Y:  focal_y_r  <= cfg_data;
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // one advance for every stage: move unless the output beat is stuck
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // angles theta (columns) and phi (rows)
  logic                    th_v, ph_v;
  logic signed [ANG_W-1:0] th_ang, ph_ang;

  swcm_angle_div u_div_th (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .coord     (in_beat.pixel_col),
    .center    (center_x_r),
    .focal     (focal_x_r),
    .out_valid (th_v),
    .angle     (th_ang)
  );

  swcm_angle_div u_div_ph (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .coord     (in_beat.pixel_row),
    .center    (center_y_r),
    .focal     (focal_y_r),
    .out_valid (ph_v),
    .angle     (ph_ang)
  );

  // sine and cosine of both angles
  logic                   th_cs_v, ph_cs_v;
  logic signed [CS_W-1:0] ct, st, cp, sp;

  swcm_cordic u_cordic_th (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (th_v),
    .angle     (th_ang),
    .out_valid (th_cs_v),
    .cos_q     (ct),
    .sin_q     (st)
  );

  swcm_cordic u_cordic_ph (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (ph_v),
    .angle     (ph_ang),
    .out_valid (ph_cs_v),
    .cos_q     (cp),
    .sin_q     (sp)
  );

  // ray products: sin t * cos p and cos t * cos p
  logic                     m1_v_r;
  logic signed [2*CS_W-1:0] px_r, pz_r;
  logic signed [CS_W-1:0]   m1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (adv) begin
      m1_v_r <= th_cs_v && ph_cs_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r   <= st * cp;
      pz_r   <= ct * cp;
      m1_y_r <= sp;
    end
  end

  // back to Q.30 with a floor shift, check the depth sign
  logic                   m2_v_r, m2_zbad_r;
  logic signed [CS_W-1:0] m2_x_r, m2_y_r, m2_z_r;
  logic signed [CS_W-1:0] z_q;

  assign z_q = pz_r[ANG_FRAC +: CS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (adv) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_x_r    <= px_r[ANG_FRAC +: CS_W];
      m2_y_r    <= m1_y_r;
      m2_z_r    <= z_q;
      m2_zbad_r <= (z_q <= 0);
    end
  end

  // numerators focal * X and focal * Y; bad depth divides by one
  logic                 m3_v_r, m3_zbad_r;
  logic signed [PN_W:0] nx_r, ny_r;
  logic [PD_W-1:0]      den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (adv) begin
      m3_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r      <= $signed({1'b0, focal_x_r}) * m2_x_r;
      ny_r      <= $signed({1'b0, focal_y_r}) * m2_y_r;
      den_r     <= m2_zbad_r ? PD_W'(1) : m2_z_r[PD_W-1:0];
      m3_zbad_r <= m2_zbad_r;
    end
  end

  // projection quotients
  logic                 qx_v, qy_v, qx_zbad, qy_zbad;
  logic signed [PN_W:0] qx, qy;

  swcm_proj_div u_pdiv_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (m3_v_r),
    .num       (nx_r),
    .den       (den_r),
    .zbad      (m3_zbad_r),
    .out_valid (qx_v),
    .quot      (qx),
    .out_zbad  (qx_zbad)
  );

  swcm_proj_div u_pdiv_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (m3_v_r),
    .num       (ny_r),
    .den       (den_r),
    .zbad      (m3_zbad_r),
    .out_valid (qy_v),
    .quot      (qy),
    .out_zbad  (qy_zbad)
  );

  // add the center, clamp, build the output beat
  logic signed [SUM_W-1:0] sx, sy;
  logic                    sat_x, sat_y, zbad;
  out_beat_t               beat_nxt, out_beat_r;

  always_comb begin
    sx    = $signed({{(SUM_W-REG_W){1'b0}}, center_x_r}) + SUM_W'(qx);
    sy    = $signed({{(SUM_W-REG_W){1'b0}}, center_y_r}) + SUM_W'(qy);
    zbad  = qx_zbad || qy_zbad;
    sat_x = (sx > SUM_HI) || (sx < SUM_LO);
    sat_y = (sy > SUM_HI) || (sy < SUM_LO);

    if (sx > SUM_HI) begin
      beat_nxt.source_x = OUT_HI;
    end else if (sx < SUM_LO) begin
      beat_nxt.source_x = OUT_LO;
    end else begin
      beat_nxt.source_x = sx[OUT_W-1:0];
    end

    if (sy > SUM_HI) begin
      beat_nxt.source_y = OUT_HI;
    end else if (sy < SUM_LO) begin
      beat_nxt.source_y = OUT_LO;
    end else begin
      beat_nxt.source_y = sy[OUT_W-1:0];
    end

    beat_nxt.out_of_range = sat_x || sat_y;

    if (zbad) begin
      beat_nxt.source_x     = OUT_HI;
      beat_nxt.source_y     = OUT_HI;
      beat_nxt.out_of_range = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= qx_v && qy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_beat_r <= beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

@@ hw/rtl/swcm_checker.sv @@
// ----------------------------------------------------------------------------
// swcm_checker
// Port-level checks on the spherical warp coordinate map, bound to the top.
// ----------------------------------------------------------------------------
module swcm_checker
  import swcm_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input in_beat_t             in_beat,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_beat_t            out_beat,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [REG_W-1:0]     cfg_data
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  // input side stalls exactly when a result beat is stuck
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // pipeline empties on reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // a valid result beat carries known bits
  a_beat_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_beat))
    else $error("unknown bits in a result beat");

endmodule

bind spherical_warp_coordinate_map swcm_checker u_swcm_checker (.*);
